// File: hw/rtl/caw_pkg.sv
// ----------------------------------------------------------------------------
// caw_pkg: shared types and constants of the CIGAR alignment walker.
// Holds the item layouts of both channels, the result kinds and the
// character codes that the walker recognizes.
// ----------------------------------------------------------------------------
package caw_pkg;

  // Width of the reference cursors; results carry the low 32 bits.
  localparam int unsigned PosWidth = 32;
  localparam int unsigned LenWidth = 28;
  localparam int unsigned OutWidth = 32;

  // Depth of the result queue and the width of its pointers and fill count.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrWidth   = $clog2(QueueDepth);
  localparam int unsigned CntWidth   = $clog2(QueueDepth + 1);

  // Largest operation length that fits the length field.
  localparam logic [LenWidth-1:0] LenMax = '1;

  // ASCII codes of the characters that carry meaning.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharM     = 8'h4D;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharX     = 8'h58;
  localparam logic [7:0] CharI     = 8'h49;
  localparam logic [7:0] CharS     = 8'h53;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharN     = 8'h4E;
  localparam logic [7:0] CharH     = 8'h48;
  localparam logic [7:0] CharP     = 8'h50;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KindMatch = 2'd0,
    KindEnd   = 2'd1,
    KindError = 2'd2
  } kind_e;

  // One input item: a CIGAR character with its record framing.
  typedef struct packed {
    logic [7:0]  cigar_char;
    logic        first_char;
    logic        last_char;
    logic [31:0] record_pos;
    logic [31:0] window_offset;
  } in_item_t;

  // One result item.
  typedef struct packed {
    kind_e                kind;
    logic [OutWidth-1:0]  read_offset;
    logic [OutWidth-1:0]  window_index;
    logic [LenWidth-1:0]  seg_length;
    logic [OutWidth-1:0]  end_position;
    logic                 final_result;
  } out_item_t;

endpackage

// File: hw/rtl/cigar_alignment_walker.sv
// Flow: an item is registered in the input stage at acceptance, and its results
// enter the result queue when the stage hands it on. Throughput: one item per
// cycle while the result queue has room for two results; an item that ends a
// record with a match operation produces two results, popped one at a time.
// The four-entry result queue sets how far the output may stall before input
// stops. Reset clears all cursors, the queue pointers and the stage valid flag.
// ----------------------------------------------------------------------------
// cigar_alignment_walker: SAM CIGAR walker.
// Decodes one CIGAR character per item, builds operation lengths from
// digits, moves the read and reference cursors and emits match segments,
// record end positions and error results.
// ----------------------------------------------------------------------------
module cigar_alignment_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  caw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output caw_pkg::out_item_t out_item_o
);
  import caw_pkg::*;

  // Input stage register.
  logic     stage_valid_q;
  in_item_t stage_q;

  // Walker state.
  logic [LenWidth-1:0] len_q, len_d;
  logic [31:0]         read_q, read_d;
  logic [PosWidth-1:0] ref_idx_q, ref_idx_d;
  logic [PosWidth-1:0] ref_end_q, ref_end_d;
  logic                failed_q, failed_d;

  // Result queue.
  out_item_t           queue_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] count_q;

  logic                stage_fire;
  logic                pop;
  logic [1:0]          push_n;
  out_item_t           res0, res1;

  // Values after the start-of-record load.
  logic [LenWidth-1:0] len_b;
  logic [31:0]         read_b;
  logic [PosWidth-1:0] ref_idx_b, ref_end_b;
  logic                failed_b;
  logic [31:0]         digit_val;
  logic                is_match, err;

  // The stage hands its item on whenever the queue has room for two results.
  assign stage_fire  = stage_valid_q && (count_q <= CntWidth'(QueueDepth - 2));
  assign in_ready_o  = !stage_valid_q || stage_fire;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = queue_q[rd_ptr_q];

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stage_q <= in_item_i;
    end
  end

  // Decode of one character against the cursors.
  always_comb begin
    if (stage_q.first_char) begin
      ref_end_b = PosWidth'(stage_q.record_pos) - PosWidth'(1);
      ref_idx_b = PosWidth'(stage_q.record_pos) - PosWidth'(1)
                  - PosWidth'(stage_q.window_offset);
      read_b    = '0;
      len_b     = '0;
      failed_b  = 1'b0;
    end else begin
      ref_end_b = ref_end_q;
      ref_idx_b = ref_idx_q;
      read_b    = read_q;
      len_b     = len_q;
      failed_b  = failed_q;
    end

    // Length times ten plus the digit, as two shifted adds.
    digit_val = {1'b0, len_b, 3'b000} + {3'b000, len_b, 1'b0}
                + {24'd0, stage_q.cigar_char - CharZero};

    len_d     = len_b;
    read_d    = read_b;
    ref_idx_d = ref_idx_b;
    ref_end_d = ref_end_b;
    failed_d  = failed_b;
    is_match  = 1'b0;
    err       = 1'b0;

    if (!failed_b) begin
      if (stage_q.cigar_char inside {[CharZero:CharNine]}) begin
        if (digit_val[31:LenWidth] != '0) begin
          err = 1'b1;
        end else begin
          len_d = digit_val[LenWidth-1:0];
        end
      end else begin
        len_d = '0;
        case (stage_q.cigar_char)
          CharM, CharEq, CharX: begin
            is_match  = 1'b1;
            read_d    = read_b + 32'(len_b);
            ref_idx_d = ref_idx_b + PosWidth'(len_b);
            ref_end_d = ref_end_b + PosWidth'(len_b);
          end
          CharI, CharS: begin
            read_d = read_b + 32'(len_b);
          end
          CharD, CharN: begin
            ref_idx_d = ref_idx_b + PosWidth'(len_b);
            ref_end_d = ref_end_b + PosWidth'(len_b);
          end
          CharH, CharP: begin
          end
          default: begin
            err   = 1'b1;
            len_d = len_b;
          end
        endcase
      end
      if (err) begin
        failed_d = 1'b1;
      end
    end
  end

  // Assembly of up to two result items.
  always_comb begin
    res0 = '0;
    res1 = '0;
    push_n = 2'd0;
    if (!failed_b) begin
      if (err) begin
        res0.kind         = KindError;
        res0.final_result = 1'b1;
        push_n            = 2'd1;
      end else begin
        if (is_match) begin
          res0.kind         = KindMatch;
          res0.read_offset  = read_b;
          res0.window_index = OutWidth'(ref_idx_b);
          res0.seg_length   = len_b;
          res0.final_result = !stage_q.last_char;
          push_n            = 2'd1;
        end
        if (stage_q.last_char) begin
          res1.kind         = KindEnd;
          res1.end_position = OutWidth'(ref_end_d - PosWidth'(1));
          res1.final_result = 1'b1;
          if (is_match) begin
            push_n = 2'd2;
          end else begin
            res0   = res1;
            push_n = 2'd1;
          end
        end
      end
    end
  end

  // Walker state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      read_q    <= '0;
      ref_idx_q <= '0;
      ref_end_q <= '0;
      failed_q  <= 1'b0;
    end else if (stage_fire) begin
      len_q     <= len_d;
      read_q    <= read_d;
      ref_idx_q <= ref_idx_d;
      ref_end_q <= ref_end_d;
      failed_q  <= failed_d;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (stage_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrWidth'(push_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrWidth'(1);
      end
      count_q <= count_q + CntWidth'(stage_fire ? push_n : 2'd0) - CntWidth'(pop);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (stage_fire && push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (stage_fire && push_n == 2'd2) begin
      queue_q[wr_ptr_q + PtrWidth'(1)] <= res1;
    end
  end

  // The fill count never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(QueueDepth))
    else $error("result queue overflow");

  // A failed record stays silent until the next start of record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && failed_q && !stage_q.first_char |-> push_n == 2'd0)
    else $error("failed record produced a result");

  // An error is always the only and final result of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && push_n != 2'd0 && res0.kind == KindError
      |-> push_n == 2'd1 && res0.final_result)
    else $error("error result not alone");

  // An item that pushes two results ends on exactly one final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && push_n == 2'd2 |-> !res0.final_result && res1.final_result)
    else $error("final flag misplaced");

  // The walker enters a failed state only through an error result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_fire && failed_d && !failed_b |-> err && push_n == 2'd1)
    else $error("failure without error result");

endmodule
